// ===== rtl/core/urx_pkg.sv =====
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types, reset values and helpers for the 8N1 receiver with byte fifo.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int unsigned FifoDepthDef = 32;

  localparam logic [7:0] BitTicksRst     = 8'd16;
  localparam logic [7:0] FirstTicksRst   = 8'd24;
  localparam logic [9:0] SilenceTicksRst = 10'd176;

  typedef enum logic [1:0] {
    PH_SILENCE,
    PH_SYNC,
    PH_DATA,
    PH_STOP
  } rx_phase_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_READ,
    OP_CLEAR
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_BIT_TICKS,
    CFG_FIRST_TICKS,
    CFG_SILENCE_TICKS
  } cfg_idx_e;

  // a programmed zero behaves as one
  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    at_least_one = (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

// ===== rtl/core/uart_rx_8n1_resync_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_rx_8n1_resync_fifo
// Tick-driven 8N1 receiver with silence resync and a byte fifo.
// ----------------------------------------------------------------------------
// Each request is a timer tick with a line sample, a fifo read or a fifo
// clear, and yields exactly one result. One request is taken every cycle;
// unless a stalled result holds the pipeline; a request waits in the input
// register, then the receiver state, fifo pointers and the fifo read port
// update as it moves into the result register, which holds the result. The
// fifo head is read from the fifo memory through a registered read port as
// each request moves on, which is why the result stage sits after the
// update. While a result waits in the result register the input register
// takes one more request and then holds the input off until the result
// leaves. After reset the receiver hunts for silence_ticks quiet ticks before
// it accepts a start bit, and does so again after every framing error.
module uart_rx_8n1_resync_fifo
  import urx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef,
  localparam int unsigned FillW     = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic             line_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             read_valid_o,
  output logic [7:0]       head_data_o,
  output logic [FillW-1:0] fill_count_o,
  output logic             byte_stored_o,
  output logic             frame_error_o,
  output logic             overflow_drop_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [9:0]       cfg_data_i
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  // configuration
  logic [7:0] bit_ticks_q, first_ticks_q;
  logic [9:0] silence_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q     <= BitTicksRst;
      first_ticks_q   <= FirstTicksRst;
      silence_ticks_q <= SilenceTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BIT_TICKS:     bit_ticks_q     <= cfg_data_i[7:0];
        CFG_FIRST_TICKS:   first_ticks_q   <= cfg_data_i[7:0];
        CFG_SILENCE_TICKS: silence_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic a_valid_q, b_valid_q;
  logic adv;
  logic [1:0] op_q;
  logic line_q;

  assign adv        = a_valid_q && (!b_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (adv) begin
        b_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= opcode_i;
      line_q <= line_level_i;
    end
  end

  // receiver and fifo state
  rx_phase_e        phase_q, phase_d;
  logic [9:0]       cnt_q, cnt_d, cnt_dec;
  logic [2:0]       bit_idx_q, bit_idx_d;
  logic [7:0]       shift_q, shift_d;
  logic             last_line_q, last_line_d;
  logic             drop_q, drop_d;
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             fall_edge, dec_zero, fifo_full;
  logic             push, pop;
  logic             stored_d, ferr_d, ovf_d, rd_valid_d;
  logic [7:0]       rd_data_d;

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       mem_rdata_q;

  assign fall_edge = last_line_q && !line_q;
  assign cnt_dec   = (cnt_q != 10'd0) ? cnt_q - 10'd1 : 10'd0;
  assign dec_zero  = (cnt_dec == 10'd0);
  assign fifo_full = (fill_q == FillW'(FIFO_DEPTH));

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (op_q == OP_TICK) begin
      case (phase_q)
        PH_SILENCE: if (!fall_edge && dec_zero) phase_d = PH_SYNC;
        PH_SYNC:    if (fall_edge) phase_d = PH_DATA;
        PH_DATA:    if (dec_zero && bit_idx_q == 3'd7) phase_d = PH_STOP;
        PH_STOP: begin
          if (dec_zero) begin
            phase_d = line_q ? PH_SYNC : PH_SILENCE;
          end
        end
        default: phase_d = PH_SILENCE;
      endcase
    end
  end

  // datapath and result flags
  always_comb begin
    cnt_d       = cnt_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    last_line_d = last_line_q;
    drop_d      = drop_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    fill_d      = fill_q;
    push        = 1'b0;
    pop         = 1'b0;
    stored_d    = 1'b0;
    ferr_d      = 1'b0;
    ovf_d       = 1'b0;
    rd_valid_d  = 1'b0;
    rd_data_d   = 8'd0;
    case (op_q)
      OP_TICK: begin
        last_line_d = line_q;
        case (phase_q)
          PH_SILENCE: begin
            cnt_d = fall_edge ? at_least_one(silence_ticks_q) : cnt_dec;
          end
          PH_SYNC: begin
            if (fall_edge) begin
              shift_d   = 8'd0;
              bit_idx_d = 3'd0;
              cnt_d     = at_least_one({2'b00, first_ticks_q});
            end
          end
          PH_DATA: begin
            cnt_d = cnt_dec;
            if (dec_zero) begin
              shift_d = {line_q, shift_q[7:1]};
              cnt_d   = at_least_one({2'b00, bit_ticks_q});
              if (bit_idx_q != 3'd7) begin
                bit_idx_d = bit_idx_q + 3'd1;
              end
            end
          end
          PH_STOP: begin
            cnt_d = cnt_dec;
            if (dec_zero) begin
              if (line_q) begin
                if (drop_q) begin
                  drop_d = 1'b0;
                end else if (!fifo_full) begin
                  push     = 1'b1;
                  stored_d = 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end else begin
                ferr_d = 1'b1;
                cnt_d  = at_least_one(silence_ticks_q);
              end
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        if (fill_q != '0) begin
          pop        = 1'b1;
          rd_valid_d = 1'b1;
          rd_data_d  = mem_rdata_q;
        end
      end
      OP_CLEAR: begin
        wptr_d = '0;
        rptr_d = '0;
        fill_d = '0;
        drop_d = 1'b1;
      end
      default: ;
    endcase
    if (push) begin
      wptr_d = (wptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      fill_d = fill_q + FillW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SILENCE;
      cnt_q       <= SilenceTicksRst;
      bit_idx_q   <= 3'd0;
      shift_q     <= 8'd0;
      last_line_q <= 1'b1;
      drop_q      <= 1'b0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      fill_q      <= '0;
    end else if (adv) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
      last_line_q <= last_line_d;
      drop_q      <= drop_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      fill_q      <= fill_d;
    end
  end

  // fifo memory, head read with write bypass
  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      mem[wptr_q] <= shift_q;
    end
    if (adv) begin
      mem_rdata_q <= (push && wptr_q == rptr_d) ? shift_q : mem[rptr_d];
    end
  end

  // result register
  logic [7:0] rd_data_q;
  logic       rd_valid_q, stored_q, ferr_q, ovf_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q  <= rd_data_d;
      rd_valid_q <= rd_valid_d;
      stored_q   <= stored_d;
      ferr_q     <= ferr_d;
      ovf_q      <= ovf_d;
    end
  end

  assign out_valid_o     = b_valid_q;
  assign read_data_o     = rd_data_q;
  assign read_valid_o    = rd_valid_q;
  assign head_data_o     = (fill_q != '0) ? mem_rdata_q : 8'd0;
  assign fill_count_o    = fill_q;
  assign byte_stored_o   = stored_q;
  assign frame_error_o   = ferr_q;
  assign overflow_drop_o = ovf_q;

endmodule

// ===== rtl/core/urx_checker.sv =====
// ----------------------------------------------------------------------------
// urx_checker
// Port-level checks for the 8N1 receiver with byte fifo.
// ----------------------------------------------------------------------------
module urx_checker
  import urx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef,
  localparam int unsigned FillW     = $clog2(FIFO_DEPTH + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [7:0]       read_data_o,
  input logic             read_valid_o,
  input logic [7:0]       head_data_o,
  input logic [FillW-1:0] fill_count_o
  ,
  input logic             byte_stored_o,
  input logic             frame_error_o,
  input logic             overflow_drop_o
);

  // a result reports at most one event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({byte_stored_o, frame_error_o, overflow_drop_o, read_valid_o}))
    else $error("more than one event flag in a result");

  // empty fifo peeks zero, failed read returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o != '0 || head_data_o == 8'd0)
                    && (read_valid_o || read_data_o == 8'd0))
    else $error("nonzero data without a byte behind it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_count_o <= FillW'(FIFO_DEPTH))
    else $error("fill count above fifo depth");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fill_count_o)
                                    && $stable(head_data_o))
    else $error("stalled result changed");

endmodule

bind uart_rx_8n1_resync_fifo urx_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_urx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .read_data_o    (read_data_o),
  .read_valid_o   (read_valid_o),
  .head_data_o    (head_data_o),
  .fill_count_o   (fill_count_o),
  .byte_stored_o  (byte_stored_o),
  .frame_error_o  (frame_error_o),
  .overflow_drop_o(overflow_drop_o)
);

// ===== tb/uart_rx_8n1_resync_fifo_tb.sv =====
// ----------------------------------------------------------------------------
// uart_rx_8n1_resync_fifo_tb
// Self-checking bench for the tick-driven 8N1 receiver with byte fifo.
// A short directed table runs first with all timing registers at zero. Then
// come serial frames built from the programmed bit period, with random
// bytes, good and bad stop bits, fifo reads and clears, line noise and the
// spare opcode. Every status word is checked against a behavioral model kept
// inside the bench or a pinned value, under random stalls on both sides in most phases.
// ----------------------------------------------------------------------------
module uart_rx_8n1_resync_fifo_tb;
  import urx_pkg::*;

  localparam int unsigned Depth         = FifoDepthDef;
  localparam logic [1:0]  OpSpare       = 2'd3;
  localparam logic [1:0]  CfgSpare      = 2'd3;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHold      = 300;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       rd_valid;
    logic [7:0] head;
    logic [5:0] fill;
    logic       stored;
    logic       ferr;
    logic       ovf;
  } rx_status_t;

  typedef struct packed {
    logic [1:0] op;
    logic       lvl;
    logic       pinned;
    rx_status_t st;
  } stim_row_t;

  localparam rx_status_t NoStatus = '0;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i        = OP_TICK;
  logic       line_level_i    = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [7:0] read_data_o;
  logic       read_valid_o;
  logic [7:0] head_data_o;
  logic [5:0] fill_count_o;
  logic       byte_stored_o;
  logic       frame_error_o;
  logic       overflow_drop_o;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i     = CFG_BIT_TICKS;
  logic [9:0] cfg_data_i      = '0;

  uart_rx_8n1_resync_fifo u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .line_level_i   (line_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .head_data_o    (head_data_o),
    .fill_count_o   (fill_count_o),
    .byte_stored_o  (byte_stored_o),
    .frame_error_o  (frame_error_o),
    .overflow_drop_o(overflow_drop_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // receiver copy kept by the bench
  logic [7:0] m_bit_ticks;
  logic [7:0] m_first_ticks;
  logic [9:0] m_silence_ticks;
  rx_phase_e  m_phase;
  logic [9:0] m_countdown;
  logic [2:0] m_bit_idx;
  logic [7:0] m_shift;
  logic       m_last_line;
  logic       m_drop_next;
  logic [7:0] m_fifo [Depth];
  logic [4:0] m_wr;
  logic [4:0] m_rd;
  logic [5:0] m_fill;

  rx_status_t rx_status_q[$];
  rx_status_t want_st;
  int         errors        = 0;
  int         sent_cnt      = 0;
  int         stall_cycles  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         read_mix_pct  = 0;
  bit         long_hold_req = 1'b0;

  task automatic reset_model();
    m_bit_ticks     = BitTicksRst;
    m_first_ticks   = FirstTicksRst;
    m_silence_ticks = SilenceTicksRst;
    m_phase         = PH_SILENCE;
    m_countdown     = SilenceTicksRst;
    m_bit_idx       = '0;
    m_shift         = '0;
    m_last_line     = 1'b1;
    m_drop_next     = 1'b0;
    m_wr            = '0;
    m_rd            = '0;
    m_fill          = '0;
    for (int i = 0; i < Depth; i++) m_fifo[i] = '0;
  endtask

  function automatic logic [9:0] floor_one(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  function automatic rx_status_t next_rx_status(input logic [1:0] op, input logic lvl);
    rx_status_t st;
    logic       fall;
    st = '0;
    case (op)
      OP_TICK: begin
        fall        = m_last_line & ~lvl;
        m_last_line = lvl;
        case (m_phase)
          PH_SILENCE: begin
            // any falling edge restarts the quiet period
            if (fall) begin
              m_countdown = floor_one(m_silence_ticks);
            end else begin
              if (m_countdown != '0) m_countdown--;
              if (m_countdown == '0) m_phase = PH_SYNC;
            end
          end
          PH_SYNC: begin
            if (fall) begin
              m_shift     = '0;
              m_bit_idx   = '0;
              m_countdown = floor_one({2'b00, m_first_ticks});
              m_phase     = PH_DATA;
            end
          end
          PH_DATA: begin
            if (m_countdown != '0) m_countdown--;
            if (m_countdown == '0) begin
              m_shift     = {lvl, m_shift[7:1]};
              m_countdown = floor_one({2'b00, m_bit_ticks});
              if (m_bit_idx == 3'd7) m_phase = PH_STOP;
              else m_bit_idx++;
            end
          end
          default: begin
            if (m_countdown != '0) m_countdown--;
            if (m_countdown == '0) begin
              if (lvl) begin
                // a pending drop eats the frame, even ahead of the full check
                if (m_drop_next) begin
                  m_drop_next = 1'b0;
                end else if (m_fill < Depth) begin
                  m_fifo[m_wr] = m_shift;
                  m_wr++;
                  m_fill++;
                  st.stored = 1'b1;
                end else begin
                  st.ovf = 1'b1;
                end
                m_phase = PH_SYNC;
              end else begin
                st.ferr     = 1'b1;
                m_phase     = PH_SILENCE;
                m_countdown = floor_one(m_silence_ticks);
              end
            end
          end
        endcase
      end
      OP_READ: begin
        if (m_fill != '0) begin
          st.rd_data  = m_fifo[m_rd];
          st.rd_valid = 1'b1;
          m_rd++;
          m_fill--;
        end
      end
      OP_CLEAR: begin
        m_wr        = '0;
        m_rd        = '0;
        m_fill      = '0;
        m_drop_next = 1'b1;
      end
      default: ;
    endcase
    st.head = (m_fill != '0) ? m_fifo[m_rd] : 8'h00;
    st.fill = m_fill;
    return st;
  endfunction

  // called right after a falling edge; leaves valid high for the next request
  task automatic issue(input logic [1:0] op, input logic lvl, input logic pinned,
                       input rx_status_t pin_st);
    rx_status_t st;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    line_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    st = next_rx_status(op, lvl);
    rx_status_q.push_back(pinned ? pin_st : st);
    if (op != OpSpare) sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send(input logic [1:0] op, input logic lvl);
    issue(op, lvl, 1'b0, NoStatus);
  endtask

  task automatic tick(input logic lvl);
    if ($urandom_range(0, 99) < read_mix_pct) send(OP_READ, 1'($urandom_range(0, 1)));
    send(OP_TICK, lvl);
  endtask

  // one frame at the programmed bit period, then gap ticks of idle line
  task automatic send_frame(input logic [7:0] data, input logic stop_lvl, input int gap);
    int b;
    b = (m_bit_ticks == '0) ? 1 : m_bit_ticks;
    repeat (b) tick(1'b0);
    for (int i = 0; i < 8; i++) repeat (b) tick(data[i]);
    repeat (b) tick(stop_lvl);
    repeat (gap) tick(1'b1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (rx_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BIT_TICKS:     m_bit_ticks     = data[7:0];
      CFG_FIRST_TICKS:   m_first_ticks   = data[7:0];
      CFG_SILENCE_TICKS: m_silence_ticks = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_timing(input int b, input int f, input int s);
    wait_idle();
    write_reg(CFG_BIT_TICKS, 10'(b));
    write_reg(CFG_FIRST_TICKS, 10'(f));
    write_reg(CFG_SILENCE_TICKS, 10'(s));
  endtask

  task automatic run_mixed(input int n);
    int stop_at;
    int r;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3));
      end else if (r < 63) begin
        // low stop bit, then enough quiet line to regain sync
        send_frame(8'($urandom_range(0, 255)), 1'b0, m_silence_ticks + $urandom_range(1, 4));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) send(OP_READ, 1'($urandom_range(0, 1)));
      end else if (r < 79) begin
        send(OP_CLEAR, 1'($urandom_range(0, 1)));
      end else if (r < 82) begin
        send(OpSpare, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rx_status_q.size() == 0) begin
        errors++;
        $error("status word with no request pending");
      end else begin
        want_st = rx_status_q.pop_front();
        check_field("read_data", want_st.rd_data, read_data_o);
        check_field("read_valid", want_st.rd_valid, read_valid_o);
        check_field("head_data", want_st.head, head_data_o);
        check_field("fill_count", want_st.fill, fill_count_o);
        check_field("byte_stored", want_st.stored, byte_stored_o);
        check_field("frame_error", want_st.ferr, frame_error_o);
        check_field("overflow_drop", want_st.ovf, overflow_drop_o);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("uart_rx_8n1_resync_fifo_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t  rows[$];
    rx_status_t pin;
    int         b;

    reset_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 15;
    recv_idle_pct = 78;
    read_mix_pct  = 3;

    // zero timing registers act as one tick each, so a frame is ten ticks
    set_timing(0, 0, 0);
    rows.push_back('{OP_READ, 1'b1, 1'b1, NoStatus});
    rows.push_back('{OpSpare, 1'b0, 1'b1, NoStatus});
    // the edge reloads the quiet count with the new value, the next tick ends it
    rows.push_back('{OP_TICK, 1'b0, 1'b1, NoStatus});
    rows.push_back('{OP_TICK, 1'b1, 1'b1, NoStatus});
    rows.push_back('{OP_TICK, 1'b0, 1'b0, NoStatus});
    repeat (8) rows.push_back('{OP_TICK, 1'b1, 1'b0, NoStatus});
    pin        = NoStatus;
    pin.head   = 8'hFF;
    pin.fill   = 6'd1;
    pin.stored = 1'b1;
    rows.push_back('{OP_TICK, 1'b1, 1'b1, pin});
    rows.push_back('{OP_TICK, 1'b0, 1'b0, NoStatus});
    repeat (8) rows.push_back('{OP_TICK, 1'b0, 1'b0, NoStatus});
    pin.stored = 1'b0;
    pin.ferr   = 1'b1;
    rows.push_back('{OP_TICK, 1'b0, 1'b1, pin});
    pin          = NoStatus;
    pin.rd_data  = 8'hFF;
    pin.rd_valid = 1'b1;
    rows.push_back('{OP_READ, 1'b0, 1'b1, pin});
    rows.push_back('{OP_CLEAR, 1'b1, 1'b1, NoStatus});
    foreach (rows[i]) issue(rows[i].op, rows[i].lvl, rows[i].pinned, rows[i].st);

    set_timing(4, 6, 12);
    write_reg(CfgSpare, 10'h2AA);
    run_mixed(200);
    // long receiver hold while requests keep coming, then a full drain
    long_hold_req = 1'b1;
    run_mixed(150);
    wait_idle();
    run_mixed(150);

    // fill the fifo past its depth with no reads, one tick per bit
    send_idle_pct = 78;
    recv_idle_pct = 15;
    read_mix_pct  = 0;
    wait_idle();
    write_reg(CFG_BIT_TICKS, 10'h301);
    write_reg(CFG_FIRST_TICKS, 10'd1);
    write_reg(CFG_SILENCE_TICKS, 10'd1);
    repeat (3) tick(1'b1);
    repeat (Depth + 3) send_frame(8'($urandom_range(0, 255)), 1'b1, 1);
    repeat (Depth + 2) send(OP_READ, 1'($urandom_range(0, 1)));
    repeat (3) send_frame(8'($urandom_range(0, 255)), 1'b1, 1);
    send(OP_CLEAR, 1'b0);
    repeat (2) send_frame(8'($urandom_range(0, 255)), 1'b1, 1);
    repeat (3) send(OP_READ, 1'($urandom_range(0, 1)));

    // largest timing values, noisy line so edges load the longest counts
    read_mix_pct = 2;
    set_timing(255, 255, 1023);
    repeat (40) tick(1'($urandom_range(0, 1)));
    send(OP_READ, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    read_mix_pct  = 3;
    repeat (2) begin
      b = $urandom_range(4, 8);
      set_timing(b, b + $urandom_range(0, b - 1), $urandom_range(1, 40));
      run_mixed(250);
    end

    in_valid_i <= 1'b0;
    while (rx_status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("uart_rx_8n1_resync_fifo_tb: done, clean");
    end else begin
      $display("uart_rx_8n1_resync_fifo_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/urx_pkg.sv
rtl/core/uart_rx_8n1_resync_fifo.sv
rtl/core/urx_checker.sv
tb/uart_rx_8n1_resync_fifo_tb.sv
